// ===== hdl/hpla_pkg.sv =====
package hpla_pkg;

    // field widths
    localparam int LAT_W = 30;
    localparam int LON_W = 31;
    localparam int RAD_W = 23;
    localparam int SEG_W = 29;
    localparam int TOT_W = 40;

    // parameter defaults
    localparam int ANGLE_FRAC_BITS_DEF = 22;
    localparam int CORDIC_STEPS_DEF    = 24;

    // queue depth between front and back
    localparam int QDEPTH = 2;

    // arithmetic constants
    localparam logic [RAD_W-1:0] RADIUS_RESET = 23'd6371000;
    localparam logic [31:0]      GAIN_Q30     = 32'd652032874;
    localparam logic [31:0]      PI_Q30       = 32'hC90F_DAA2;
    localparam logic [30:0]      A_ONE        = 31'h4000_0000;

    // item classes
    localparam logic [1:0] KIND_FIRST  = 2'd0;
    localparam logic [1:0] KIND_NOPREV = 2'd1;
    localparam logic [1:0] KIND_SEG    = 2'd2;

    typedef struct packed {
        logic [1:0]              kind;
        logic                    last;
        logic signed [LAT_W-1:0] lat1;
        logic signed [LAT_W-1:0] lat2;
        logic signed [LAT_W:0]   dlat;
        logic signed [LON_W:0]   dlon;
    } t_job;

    // arctangent of 2^-k in turns * 2^32
    function automatic logic [31:0] atan_turn(input logic [4:0] k);
        logic [31:0] v;
        case (k)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/hpla_if.sv =====
// track point channel
interface hpla_pt_if import hpla_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [LAT_W-1:0] latitude;
    logic signed [LON_W-1:0] longitude;
    logic                    first_point;
    logic                    last_point;
    modport source(output valid, latitude, longitude, first_point, last_point, input ready);
    modport sink(input valid, latitude, longitude, first_point, last_point, output ready);
endinterface

// result channel
interface hpla_res_if import hpla_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SEG_W-1:0] segment_distance;
    logic [TOT_W-1:0] total_length;
    logic             path_end;
    modport source(output valid, segment_distance, total_length, path_end, input ready);
    modport sink(input valid, segment_distance, total_length, path_end, output ready);
endinterface

// radius write channel
interface hpla_cfg_if import hpla_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [RAD_W-1:0] earth_radius_m;
    modport source(output valid, earth_radius_m, input ready);
    modport sink(input valid, earth_radius_m, output ready);
endinterface

// ===== hdl/hpla_front.sv =====
module hpla_front import hpla_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    hpla_pt_if.sink i_pt,
    output logic    o_push,
    output t_job    o_job,
    input  logic    i_full
);

    logic signed [LAT_W-1:0] r_prev_lat;
    logic signed [LON_W-1:0] r_prev_lon;
    logic                    r_have;
    logic                    accept;

    assign i_pt.ready = !i_full;
    assign accept     = i_pt.valid && !i_full;
    assign o_push     = accept;

    // classify the item and form the differences to the previous point
    always_comb begin
        if (i_pt.first_point) begin
            o_job.kind = KIND_FIRST;
        end else if (r_have) begin
            o_job.kind = KIND_SEG;
        end else begin
            o_job.kind = KIND_NOPREV;
        end
        o_job.last = i_pt.last_point;
        o_job.lat1 = r_prev_lat;
        o_job.lat2 = i_pt.latitude;
        o_job.dlat = {i_pt.latitude[LAT_W-1], i_pt.latitude}
                   - {r_prev_lat[LAT_W-1], r_prev_lat};
        o_job.dlon = {i_pt.longitude[LON_W-1], i_pt.longitude}
                   - {r_prev_lon[LON_W-1], r_prev_lon};
    end

    // previous point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have     <= 1'b0;
            r_prev_lat <= '0;
            r_prev_lon <= '0;
        end else if (accept) begin
            r_have     <= 1'b1;
            r_prev_lat <= i_pt.latitude;
            r_prev_lon <= i_pt.longitude;
        end
    end

endmodule

// ===== hdl/hpla_queue.sv =====
module hpla_queue import hpla_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_avail,
    output t_job o_job
);

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    t_job             r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(QDEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/hpla_back.sv =====
module hpla_back import hpla_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_avail,
    input  t_job       i_job,
    output logic       o_pop,
    hpla_cfg_if.sink   i_cfg,
    hpla_res_if.source o_res
);

    localparam int SH_HALF = 31 - ANGLE_FRAC_BITS;
    localparam int SH_FULL = 32 - ANGLE_FRAC_BITS;
    localparam int CNT_W   = 5;
    localparam int CW      = 34;

    // reciprocals of 45: ceil(2^38 / 45) for 32-bit and ceil(2^25 / 45) for 19-bit dividends
    localparam logic [32:0] RCP45_A = 33'd6108397933;
    localparam logic [19:0] RCP45_W = 20'd745655;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIVI  = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_ROTI  = 4'd3;
    localparam logic [3:0] S_CORD  = 4'd4;
    localparam logic [3:0] S_CDONE = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_MRES  = 4'd7;
    localparam logic [3:0] S_SQRT  = 4'd8;
    localparam logic [3:0] S_SQD   = 4'd9;
    localparam logic [3:0] S_ACC   = 4'd10;
    localparam logic [3:0] S_DIVQ  = 4'd11;
    localparam logic [3:0] S_DIVW  = 4'd12;

    localparam logic [2:0] OP_SA2 = 3'd0;
    localparam logic [2:0] OP_SO2 = 3'd1;
    localparam logic [2:0] OP_CC  = 3'd2;
    localparam logic [2:0] OP_A   = 3'd3;
    localparam logic [2:0] OP_C   = 3'd4;
    localparam logic [2:0] OP_SEG = 3'd5;

    function automatic logic [32:0] mag(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] n;
        n = -v;
        return v[CW-1] ? n[32:0] : v[32:0];
    endfunction

    logic [3:0]           r_state;
    t_job                 r_job;
    logic [1:0]           r_j;
    logic [CNT_W-1:0]     r_cnt;
    logic [31:0]          r_dabs;
    logic                 r_half;
    logic [64:0]          r_qp;
    logic [31:0]          r_qhi;
    logic [18:0]          r_w;
    logic [38:0]          r_wp;
    logic                 r_neg;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [CW-1:0] r_z;
    logic                 r_rot;
    logic                 r_flip;
    logic signed [CW-1:0] r_c1;
    logic signed [CW-1:0] r_sa2;
    logic signed [CW-1:0] r_so2;
    logic [32:0]          r_ma;
    logic [32:0]          r_mb;
    logic                 r_mneg;
    logic [2:0]           r_op;
    logic [65:0]          r_prod;
    logic [30:0]          r_a;
    logic [60:0]          r_sv;
    logic [61:0]          r_root;
    logic [60:0]          r_sbit;
    logic                 r_ssel;
    logic [30:0]          r_sqy;
    logic [SEG_W-1:0]     r_seg;
    logic [TOT_W-1:0]     r_total;
    logic [RAD_W-1:0]     r_radius;
    logic                 r_out_valid;
    logic [SEG_W-1:0]     r_out_seg;
    logic [TOT_W-1:0]     r_out_tot;
    logic                 r_out_end;

    logic [32:0]          div_src;
    logic                 div_neg;
    logic [32:0]          div_abs;
    logic [26:0]          q45;
    logic [5:0]           q45x;
    logic [5:0]           r45;
    logic [18:0]          w_half;
    logic [18:0]          w_full;
    logic [31:0]          qsh;
    logic [31:0]          qsum;
    logic [31:0]          turn;
    logic                 fold;
    logic [31:0]          fold_sum;
    logic [31:0]          u;
    logic [4:0]           k;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] at;
    logic                 d_plus;
    logic signed [CW-1:0] s_val;
    logic signed [CW-1:0] c_val;
    logic [66:0]          rnd30_sum;
    logic [66:0]          rnd26_sum;
    logic signed [CW-1:0] m_res;
    logic [31:0]          c32;
    logic signed [CW:0]   a_sum;
    logic [30:0]          a_clamp;
    logic [61:0]          trial;
    logic                 s_ge;
    logic [30:0]          theta;
    logic [TOT_W:0]       tsum;
    logic [TOT_W-1:0]     tsat;
    logic [TOT_W-1:0]     new_total;
    logic                 out_load;

    assign i_cfg.ready = 1'b1;
    assign o_pop       = (r_state == S_IDLE) && i_avail;
    assign out_load    = (r_state == S_ACC) && (!r_out_valid || o_res.ready);

    assign o_res.valid            = r_out_valid;
    assign o_res.segment_distance = r_out_seg;
    assign o_res.total_length     = r_out_tot;
    assign o_res.path_end         = r_out_end;

    // angle source for the degree to turn conversion
    always_comb begin
        case (r_j)
            2'd0:    div_src = {{2{r_job.dlat[LAT_W]}}, r_job.dlat};
            2'd1:    div_src = {r_job.dlon[LON_W], r_job.dlon};
            2'd2:    div_src = {{3{r_job.lat1[LAT_W-1]}}, r_job.lat1};
            default: div_src = {{3{r_job.lat2[LAT_W-1]}}, r_job.lat2};
        endcase
        div_neg = div_src[32];
        div_abs = div_neg ? -div_src : div_src;
    end

    // divide by 360 as magnitude/45 scaled by 2^(sh-3) plus a small remainder term
    always_comb begin
        q45    = r_qp[64:38];
        q45x   = {q45[0], 5'd0} + {q45[2:0], 3'd0} + {q45[3:0], 2'd0} + q45[5:0];
        r45    = r_dabs[5:0] - q45x;
        w_half = (19'(r45) << (SH_HALF - 3)) + 19'd22;
        w_full = (19'(r45) << (SH_FULL - 3)) + 19'd22;
        qsh    = r_half ? (32'(q45) << (SH_HALF - 3)) : (32'(q45) << (SH_FULL - 3));
    end

    // signed turn and fold into the right half plane
    always_comb begin
        qsum     = r_qhi + 32'(r_wp[38:25]);
        turn     = r_neg ? -qsum : qsum;
        fold_sum = turn + 32'h4000_0000;
        fold     = fold_sum[31];
        u        = fold ? (turn ^ 32'h8000_0000) : turn;
    end

    // shared cordic step
    always_comb begin
        k      = r_cnt[4:0];
        xs     = r_x >>> k;
        ys     = r_y >>> k;
        at     = $signed({2'b00, atan_turn(k)});
        d_plus = r_rot ? !r_z[CW-1] : !(r_y > 0);
        s_val  = r_flip ? -r_y : r_y;
        c_val  = r_flip ? -r_x : r_x;
    end

    // product rounding
    always_comb begin
        rnd30_sum = {1'b0, r_prod} + (67'd1 << 29);
        rnd26_sum = {1'b0, r_prod} + (67'd1 << 25);
        m_res     = r_mneg ? -$signed(rnd30_sum[30+CW-1:30]) : $signed(rnd30_sum[30+CW-1:30]);
        c32       = rnd30_sum[61:30];
        a_sum     = {r_sa2[CW-1], r_sa2} + {m_res[CW-1], m_res};
        if (a_sum[CW]) begin
            a_clamp = '0;
        end else if (a_sum > $signed({4'b0000, A_ONE})) begin
            a_clamp = A_ONE;
        end else begin
            a_clamp = a_sum[30:0];
        end
    end

    // square root step, theta clamp and saturating total
    always_comb begin
        trial = r_root + {1'b0, r_sbit};
        s_ge  = ({1'b0, r_sv} >= trial);
        if (r_z[CW-1]) begin
            theta = '0;
        end else if (r_z > $signed({3'b000, A_ONE})) begin
            theta = A_ONE;
        end else begin
            theta = r_z[30:0];
        end
        tsum      = {1'b0, r_total} + (TOT_W + 1)'(r_seg);
        tsat      = tsum[TOT_W] ? '1 : tsum[TOT_W-1:0];
        new_total = (r_job.kind == KIND_FIRST) ? '0 : tsat;
    end

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_radius    <= RADIUS_RESET;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_j         <= '0;
            r_op        <= OP_SA2;
            r_rot       <= 1'b1;
            r_ssel      <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_radius <= i_cfg.earth_radius_m;
            end
            if (r_out_valid && o_res.ready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_avail) begin
                        r_job <= i_job;
                        r_j   <= 2'd0;
                        if (i_job.kind == KIND_SEG) begin
                            r_state <= S_DIVI;
                        end else begin
                            r_seg   <= '0;
                            r_state <= S_ACC;
                        end
                    end
                end
                S_DIVI: begin
                    r_dabs  <= div_abs[31:0];
                    r_neg   <= div_neg;
                    r_half  <= (r_j < 2'd2);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_qp    <= r_dabs * RCP45_A;
                    r_state <= S_DIVQ;
                end
                S_DIVQ: begin
                    r_qhi   <= qsh;
                    r_w     <= r_half ? w_half : w_full;
                    r_state <= S_DIVW;
                end
                S_DIVW: begin
                    r_wp    <= r_w * RCP45_W;
                    r_state <= S_ROTI;
                end
                S_ROTI: begin
                    r_x     <= $signed({2'b00, GAIN_Q30});
                    r_y     <= '0;
                    r_z     <= $signed({{2{u[31]}}, u});
                    r_flip  <= fold;
                    r_rot   <= 1'b1;
                    r_cnt   <= '0;
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    if (d_plus) begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                        r_z <= r_z - at;
                    end else begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                        r_z <= r_z + at;
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) begin
                        r_state <= S_CDONE;
                    end
                end
                S_CDONE: begin
                    if (r_rot) begin
                        case (r_j)
                            2'd0, 2'd1: begin
                                r_ma    <= mag(s_val);
                                r_mb    <= mag(s_val);
                                r_mneg  <= 1'b0;
                                r_op    <= (r_j == 2'd0) ? OP_SA2 : OP_SO2;
                                r_state <= S_MUL;
                            end
                            2'd2: begin
                                r_c1    <= c_val;
                                r_j     <= 2'd3;
                                r_state <= S_DIVI;
                            end
                            default: begin
                                r_ma    <= mag(r_c1);
                                r_mb    <= mag(c_val);
                                r_mneg  <= r_c1[CW-1] ^ c_val[CW-1];
                                r_op    <= OP_CC;
                                r_state <= S_MUL;
                            end
                        endcase
                    end else begin
                        r_ma    <= {2'b00, theta};
                        r_mb    <= {1'b0, PI_Q30};
                        r_mneg  <= 1'b0;
                        r_op    <= OP_C;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= r_ma * r_mb;
                    r_state <= S_MRES;
                end
                S_MRES: begin
                    case (r_op)
                        OP_SA2: begin
                            r_sa2   <= m_res;
                            r_j     <= 2'd1;
                            r_state <= S_DIVI;
                        end
                        OP_SO2: begin
                            r_so2   <= m_res;
                            r_j     <= 2'd2;
                            r_state <= S_DIVI;
                        end
                        OP_CC: begin
                            r_ma    <= mag(m_res);
                            r_mb    <= mag(r_so2);
                            r_mneg  <= m_res[CW-1] ^ r_so2[CW-1];
                            r_op    <= OP_A;
                            r_state <= S_MUL;
                        end
                        OP_A: begin
                            r_a     <= a_clamp;
                            r_sv    <= {a_clamp, 30'd0};
                            r_root  <= '0;
                            r_sbit  <= 61'd1 << 60;
                            r_ssel  <= 1'b0;
                            r_cnt   <= '0;
                            r_state <= S_SQRT;
                        end
                        OP_C: begin
                            r_ma    <= {10'd0, r_radius};
                            r_mb    <= {1'b0, c32};
                            r_mneg  <= 1'b0;
                            r_op    <= OP_SEG;
                            r_state <= S_MUL;
                        end
                        OP_SEG: begin
                            r_seg   <= rnd26_sum[26+SEG_W-1:26];
                            r_state <= S_ACC;
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_SQRT: begin
                    if (s_ge) begin
                        r_sv   <= r_sv - trial[60:0];
                        r_root <= (r_root >> 1) + {1'b0, r_sbit};
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_sbit <= r_sbit >> 2;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(30)) begin
                        r_state <= S_SQD;
                    end
                end
                S_SQD: begin
                    r_cnt <= '0;
                    if (!r_ssel) begin
                        r_sqy   <= r_root[30:0];
                        r_sv    <= {A_ONE - r_a, 30'd0};
                        r_root  <= '0;
                        r_sbit  <= 61'd1 << 60;
                        r_ssel  <= 1'b1;
                        r_state <= S_SQRT;
                    end else begin
                        r_x     <= $signed({3'b000, r_root[30:0]});
                        r_y     <= $signed({3'b000, r_sqy});
                        r_z     <= '0;
                        r_rot   <= 1'b0;
                        r_state <= S_CORD;
                    end
                end
                S_ACC: begin
                    if (out_load) begin
                        r_total     <= new_total;
                        r_out_valid <= 1'b1;
                        r_out_seg   <= r_seg;
                        r_out_tot   <= new_total;
                        r_out_end   <= r_job.last;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // a new path restarts the total at zero
    a_first_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_job.kind == KIND_FIRST) |=> (r_total == '0 && r_out_tot == '0))
        else $error("total not cleared on first point");

    // the total only grows within a path
    a_total_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_job.kind != KIND_FIRST) |=> (r_total >= $past(r_total)))
        else $error("running total decreased");

    // square root operand stays within one
    a_a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |-> (r_a <= A_ONE))
        else $error("haversine term out of range");

    // items without a segment report zero distance
    a_no_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC && r_job.kind != KIND_SEG) |-> (r_seg == '0))
        else $error("nonzero distance without a segment");

endmodule

// ===== hdl/haversine_path_length_accumulator_core.sv =====
// Track-point path length: each accepted point (latitude, longitude in degrees
// times 2^ANGLE_FRAC_BITS) yields one result with the great-circle distance from
// the previous point and the saturating running total, both in 1/16 metre.
// first_point starts a new path and clears the total; last_point is echoed as
// path_end. A front stage takes points and forms coordinate differences into a
// two-entry queue, so points are taken while the back end computes. The back
// end runs one point at a time through a reciprocal-multiply divide by 360, one
// shared CORDIC, one multiplier and a bit-serial square root. A point that forms
// a segment holds the back end through four sine/cosine CORDIC passes, the
// vectoring pass and two 31-step square roots; a first point or a point with
// no predecessor skips them and goes straight to the output. A result waiting
// in the output register stalls the back end until it is taken. The earth
// radius register may be written at any idle time and takes effect on the
// next point.
module haversine_path_length_accumulator_core import hpla_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hpla_pt_if.sink    i_pt,
    hpla_cfg_if.sink   i_cfg,
    hpla_res_if.source o_res
);

    logic push;
    logic full;
    logic pop;
    logic avail;
    t_job push_job;
    t_job pop_job;

    // accept and classify
    hpla_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (i_pt),
        .o_push  (push),
        .o_job   (push_job),
        .i_full  (full)
    );

    // decoupling queue
    hpla_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_avail (avail),
        .o_job   (pop_job)
    );

    // distance computation and accumulation
    hpla_back #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STEPS    (CORDIC_STEPS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (avail),
        .i_job   (pop_job),
        .o_pop   (pop),
        .i_cfg   (i_cfg),
        .o_res   (o_res)
    );

endmodule
